[rtl/lts_pkg.sv]
package lts_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int PATTERN_MAX_DEF   = 16;
  localparam int POSITION_BITS_DEF = 24;

  // Fixed field widths.
  localparam int BEGIN_W       = 25;
  localparam int LEN_REG_W     = 5;
  localparam int MODE_W        = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int PAT_REG_BYTES = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_POS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LOW    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_HIGH   = 3'd6;

  // Mode register bit positions.
  localparam int MODE_CASE     = 0;
  localparam int MODE_WORD     = 1;
  localparam int MODE_BACKWARD = 2;
  localparam int MODE_WRAP     = 3;

  // Match information handed from the cell row to the tracker.
  typedef struct packed {
    logic hit;
    logic need_right;
    logic cur_bnd;
    logic last;
  } lts_match_t;

  // Selection controls for the tracker.
  typedef struct packed {
    logic                      backward;
    logic                      wrap;
    logic signed [BEGIN_W-1:0] begin_pos;
  } lts_sel_cfg_t;

  // Whitespace is space and the codes from tab to carriage return.
  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Whitespace or a delimiter from the bitmap; codes above 127 never delimit.
  function automatic logic is_boundary(input logic [7:0] c, input logic [127:0] dmap);
    return is_space(c) || (!c[7] && dmap[c[6:0]]);
  endfunction

  // ASCII upper case letters fold to lower case when enabled.
  function automatic logic [7:0] fold_case(input logic [7:0] c, input logic en);
    if (en && (c >= 8'h41) && (c <= 8'h5A)) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  // Pattern byte i; bytes beyond the two pattern registers read as zero.
  function automatic logic [7:0] pat_byte(input logic [127:0] pat, input int unsigned i);
    if (i < PAT_REG_BYTES) begin
      return pat[{i[3:0], 3'b000} +: 8];
    end
    return 8'h00;
  endfunction

endpackage

[rtl/lts_if.sv]
// Text byte channel.
interface lts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       is_last;

  modport source (output valid, output text_byte, output is_last, input ready);
  modport sink (input valid, input text_byte, input is_last, output ready);
endinterface

// Search result channel.
interface lts_out_if #(
  parameter int POSITION_BITS = 24
);
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic [POSITION_BITS-1:0] match_start;
  logic [POSITION_BITS:0]   match_end;

  modport source (output valid, output found, output match_start, output match_end,
                  input ready);
  modport sink (input valid, input found, input match_start, input match_end,
                output ready);
endinterface

[rtl/lts_cell.sv]
module lts_cell (
  input  logic         clk,
  input  logic         shift_en,
  input  logic [7:0]   byte_in,
  input  logic [7:0]   pat_byte_in,
  input  logic         active,
  input  logic         fold_en,
  input  logic [127:0] dmap,
  output logic [7:0]   byte_q,
  output logic         eq,
  output logic         bnd
);
  import lts_pkg::*;

  logic [7:0] byte_r;

  // The window byte moves one cell along on every accepted beat.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  // Compare against the pattern byte aligned to this cell; idle cells agree.
  assign eq     = !active || (fold_case(byte_r, fold_en) == fold_case(pat_byte_in, fold_en));
  assign bnd    = is_boundary(byte_r, dmap);
  assign byte_q = byte_r;

endmodule

[rtl/lts_tracker.sv]
module lts_tracker #(
  parameter int PATTERN_MAX   = lts_pkg::PATTERN_MAX_DEF,
  parameter int POSITION_BITS = lts_pkg::POSITION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  lts_pkg::lts_match_t              match,
  input  logic [$clog2(PATTERN_MAX+1)-1:0] len,
  input  lts_pkg::lts_sel_cfg_t            sel_cfg,
  output logic                             res_valid,
  output logic                             res_found,
  output logic [POSITION_BITS-1:0]         res_start,
  output logic [POSITION_BITS:0]           res_end
);
  import lts_pkg::*;

  localparam int CMP_W = ((POSITION_BITS > BEGIN_W) ? POSITION_BITS : BEGIN_W) + 1;

  typedef struct packed {
    logic                     valid;
    logic [POSITION_BITS-1:0] start;
    logic [POSITION_BITS:0]   fin;
  } cand_t;

  typedef struct packed {
    cand_t faa;
    cand_t fo;
    cand_t lab;
    cand_t lo;
  } cand_set_t;

  cand_set_t                set_r;
  cand_set_t                set_a;
  cand_set_t                set_b;
  cand_t                    pend_r;
  cand_t                    new_c;
  cand_t                    sel;
  logic                     need_right_r;
  logic [POSITION_BITS-1:0] pos_r;
  logic signed [CMP_W-1:0]  b_ext;
  logic signed [CMP_W-1:0]  b_floor;
  logic                     b_neg;
  logic                     old_ok;

  // Record a confirmed match in the four running selections.
  function automatic cand_set_t confirm(input cand_set_t s, input cand_t c,
                                        input logic ge_floor, input logic le_begin);
    cand_set_t r;
    r = s;
    if (!r.fo.valid) begin
      r.fo = c;
    end
    if (!r.faa.valid && ge_floor) begin
      r.faa = c;
    end
    if (le_begin) begin
      r.lab = c;
    end
    r.lo = c;
    return r;
  endfunction

  function automatic logic [CMP_W-1:0] start_ext(input logic [POSITION_BITS-1:0] s);
    return {{(CMP_W-POSITION_BITS){1'b0}}, s};
  endfunction

  // Confirm the held candidate, then take the new one; the end of the text
  // confirms a fresh candidate at once.
  always_comb begin
    b_neg   = sel_cfg.begin_pos[BEGIN_W-1];
    b_ext   = {{(CMP_W-BEGIN_W){b_neg}}, sel_cfg.begin_pos};
    b_floor = b_neg ? '0 : b_ext;

    old_ok = pend_r.valid && (!need_right_r || match.cur_bnd);
    set_a  = set_r;
    if (old_ok) begin
      set_a = confirm(set_r, pend_r,
                      signed'(start_ext(pend_r.start)) >= b_floor,
                      !b_neg && (signed'(start_ext(pend_r.start)) <= b_ext));
    end

    new_c.valid = match.hit;
    new_c.start = pos_r - POSITION_BITS'(len) + POSITION_BITS'(1);
    new_c.fin   = {1'b0, new_c.start} + (POSITION_BITS+1)'(len);

    set_b = set_a;
    if (match.last && match.hit) begin
      set_b = confirm(set_a, new_c,
                      signed'(start_ext(new_c.start)) >= b_floor,
                      !b_neg && (signed'(start_ext(new_c.start)) <= b_ext));
    end

    sel = '0;
    if (sel_cfg.backward) begin
      if (!b_neg && set_b.lab.valid) begin
        sel = set_b.lab;
      end else if (sel_cfg.wrap && set_b.lo.valid) begin
        sel = set_b.lo;
      end
    end else begin
      if (set_b.faa.valid) begin
        sel = set_b.faa;
      end else if (sel_cfg.wrap && set_b.fo.valid) begin
        sel = set_b.fo;
      end
    end
  end

  assign res_valid = step && match.last;
  assign res_found = sel.valid;
  assign res_start = sel.start;
  assign res_end   = sel.fin;

  // Text state; the final byte clears it for the next text.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_r        <= '0;
      pend_r       <= '0;
      need_right_r <= 1'b0;
      pos_r        <= '0;
    end else if (step) begin
      if (match.last) begin
        set_r        <= '0;
        pend_r       <= '0;
        need_right_r <= 1'b0;
        pos_r        <= '0;
      end else begin
        set_r        <= set_a;
        pend_r       <= new_c;
        need_right_r <= match.need_right;
        pos_r        <= pos_r + POSITION_BITS'(1);
      end
    end
  end

  a_text_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    step && match.last |=> !pend_r.valid && (pos_r == '0))
    else $error("text state not cleared after the final byte");

  a_first_implies_last: assert property (@(posedge clk) disable iff (!rst_n)
    set_r.fo.valid |-> set_r.lo.valid)
    else $error("first match held without a last match");

  a_after_implies_first: assert property (@(posedge clk) disable iff (!rst_n)
    set_r.faa.valid |-> set_r.fo.valid)
    else $error("match after begin held without a first match");

endmodule

[rtl/literal_text_search.sv]
// Channel  | Direction | Beat payload                     | Notes
// in_ch    | sink      | text_byte, is_last               | one text byte per beat
// out_ch   | source    | found, match_start, match_end    | one beat per text
// cfg_*    | write     | cfg_index, cfg_data              | taken whenever cfg_we
//
// One text byte is taken per cycle while in_ready is high; the byte row shifts
// on the beat and the pattern compare across all cells plus candidate tracking
// happens in the next cycle; the output or skid slot then registers a result.
// Reset is synchronous and clears the registers, the fill count and all
// candidates. Two result slots let bytes keep flowing while a result stalls;
// input stalls only while both slots are, or are about to be, occupied.
module literal_text_search #(
  parameter int PATTERN_MAX   = lts_pkg::PATTERN_MAX_DEF,
  parameter int POSITION_BITS = lts_pkg::POSITION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lts_pkg::CFG_DATA_W-1:0]   cfg_data,
  lts_in_if.sink                           in_ch,
  lts_out_if.source                        out_ch
);
  import lts_pkg::*;

  localparam int DEPTH  = PATTERN_MAX + 1;
  localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int FILL_W = $clog2(PATTERN_MAX + 2);

  typedef struct packed {
    logic                     found;
    logic [POSITION_BITS-1:0] start;
    logic [POSITION_BITS:0]   fin;
  } res_t;

  logic [63:0]         pattern_low_r;
  logic [63:0]         pattern_high_r;
  logic [LEN_REG_W-1:0] pattern_length_r;
  logic [MODE_W-1:0]   mode_r;
  logic [BEGIN_W-1:0]  begin_pos_r;
  logic [63:0]         delim_low_r;
  logic [63:0]         delim_high_r;

  logic                in_accept;
  logic                in_ready;
  logic                s1_valid_r;
  logic                s1_last_r;
  logic                text_start_r;
  logic [FILL_W-1:0]   fill_cnt_r;
  logic [FILL_W-1:0]   fill_base;
  logic [FILL_W-1:0]   fill_nxt;

  logic [127:0]        pat_all;
  logic [127:0]        dmap;
  logic [LEN_W-1:0]    len;
  logic                word;
  logic                fold_en;
  logic [7:0]          pat0;
  logic [7:0]          pat_end;
  logic                left_ok;

  logic [7:0]          cell_in   [DEPTH];
  logic [7:0]          cell_q    [DEPTH];
  logic [7:0]          cell_pat  [DEPTH];
  logic [DEPTH-1:0]    cell_act;
  logic [DEPTH-1:0]    cell_eq;
  logic [DEPTH-1:0]    cell_bnd;

  lts_match_t          match;
  lts_sel_cfg_t        sel_cfg;
  logic                res_valid;
  res_t                res;
  res_t                out_r;
  res_t                skid_r;
  logic                out_valid_r;
  logic                skid_valid_r;
  logic                pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      pattern_length_r <= '0;
      mode_r           <= '0;
      begin_pos_r      <= '0;
      delim_low_r      <= '0;
      delim_high_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_LOW:  pattern_low_r    <= cfg_data;
        CFG_PATTERN_HIGH: pattern_high_r   <= cfg_data;
        CFG_PATTERN_LEN:  pattern_length_r <= cfg_data[LEN_REG_W-1:0];
        CFG_MODE:         mode_r           <= cfg_data[MODE_W-1:0];
        CFG_BEGIN_POS:    begin_pos_r      <= cfg_data[BEGIN_W-1:0];
        CFG_DELIM_LOW:    delim_low_r      <= cfg_data;
        CFG_DELIM_HIGH:   delim_high_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input acceptance: hold off only when no result slot would be free.
  assign in_ready    = !skid_valid_r &&
                       !(s1_valid_r && s1_last_r && out_valid_r && !out_ch.ready);
  assign in_ch.ready = in_ready;
  assign in_accept   = in_ch.valid && in_ready;

  // Fill count saturates one past the longest pattern; a new text restarts it.
  always_comb begin
    fill_base = text_start_r ? '0 : fill_cnt_r;
    fill_nxt  = fill_base;
    if (32'(fill_base) < PATTERN_MAX + 1) begin
      fill_nxt = fill_base + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s1_last_r    <= 1'b0;
      text_start_r <= 1'b1;
      fill_cnt_r   <= '0;
    end else begin
      s1_valid_r <= in_accept;
      if (in_accept) begin
        s1_last_r    <= in_ch.is_last;
        text_start_r <= in_ch.is_last;
        fill_cnt_r   <= fill_nxt;
      end
    end
  end

  // Pattern alignment: cell k holds the byte that meets pattern byte len-1-k.
  assign pat_all = {pattern_high_r, pattern_low_r};
  assign dmap    = {delim_high_r, delim_low_r};
  assign word    = mode_r[MODE_WORD];
  assign fold_en = mode_r[MODE_CASE];
  assign len     = (32'(pattern_length_r) > PATTERN_MAX) ? LEN_W'(PATTERN_MAX)
                                                         : LEN_W'(pattern_length_r);
  assign pat0    = pat_byte(pat_all, 0);
  assign pat_end = pat_byte(pat_all, 32'(len) - 1);

  // The row of cells forms the text window, newest byte in cell zero.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = in_ch.text_byte;
    end else begin : g_body
      assign cell_in[k] = cell_q[k-1];
    end
    assign cell_act[k] = (32'(len) > k);
    assign cell_pat[k] = pat_byte(pat_all, 32'(len) - k - 1);

    lts_cell u_cell (
      .clk         (clk),
      .shift_en    (in_accept),
      .byte_in     (cell_in[k]),
      .pat_byte_in (cell_pat[k]),
      .active      (cell_act[k]),
      .fold_en     (fold_en),
      .dmap        (dmap),
      .byte_q      (cell_q[k]),
      .eq          (cell_eq[k]),
      .bnd         (cell_bnd[k])
    );
  end

  // Whole-word rule on the left: text start, a boundary before the match or as pattern byte 0.
  assign left_ok = !word || is_boundary(pat0, dmap) || (32'(fill_cnt_r) == 32'(len))
                   || cell_bnd[len];

  always_comb begin
    match.hit        = (len != '0) && (32'(fill_cnt_r) >= 32'(len)) && (&cell_eq) && left_ok;
    match.need_right = word && !is_boundary(pat_end, dmap);
    match.cur_bnd    = cell_bnd[0];
    match.last       = s1_last_r;
  end

  assign sel_cfg.backward  = mode_r[MODE_BACKWARD];
  assign sel_cfg.wrap      = mode_r[MODE_WRAP];
  assign sel_cfg.begin_pos = begin_pos_r;

  lts_tracker #(
    .PATTERN_MAX   (PATTERN_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_valid_r),
    .match     (match),
    .len       (len),
    .sel_cfg   (sel_cfg),
    .res_valid (res_valid),
    .res_found (res.found),
    .res_start (res.start),
    .res_end   (res.fin)
  );

  // Output register with a skid slot behind it.
  assign pop = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= res_valid;
        if (res_valid) begin
          skid_r <= res;
        end
      end else begin
        out_valid_r <= res_valid;
        if (res_valid) begin
          out_r <= res;
        end
      end
    end else if (res_valid) begin
      skid_r       <= res;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_r.found;
  assign out_ch.match_start = out_r.start;
  assign out_ch.match_end   = out_r.fin;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !skid_valid_r)
    else $error("result produced with both result slots full");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot holds a result while the output register is empty");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_cnt_r) <= PATTERN_MAX + 1)
    else $error("fill count beyond the window");

endmodule

[tb/tb_literal_text_search.sv]
`timescale 1ns / 1ps

module tb_literal_text_search;
  import lts_pkg::*;

  localparam int PAT_MAX       = PATTERN_MAX_DEF;
  localparam int POS_BITS      = POSITION_BITS_DEF;
  localparam int WIN_DEPTH     = PAT_MAX + 2;
  localparam int RANDOM_BYTES  = 1650;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_REPORTS   = 10;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_BLOCKS} rx_style_e;

  typedef logic [7:0] text_t [$];

  typedef struct {
    logic [63:0]        pat_lo;
    logic [63:0]        pat_hi;
    logic [4:0]         plen;
    logic [3:0]         mode;
    logic signed [24:0] begin_at;
    logic [63:0]        dmap_lo;
    logic [63:0]        dmap_hi;
  } search_cfg_t;

  typedef struct packed {
    logic                ok;
    logic [POS_BITS-1:0] start;
    logic [POS_BITS:0]   stop;
    logic                need_right;
  } match_t;

  typedef struct packed {
    logic                found;
    logic [POS_BITS-1:0] start;
    logic [POS_BITS:0]   stop;
  } result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lts_in_if in_bus ();
  lts_out_if #(.POSITION_BITS(POS_BITS)) out_bus ();

  literal_text_search #(
    .PATTERN_MAX  (PAT_MAX),
    .POSITION_BITS(POS_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_bus),
    .out_ch   (out_bus)
  );

  // Shadow of the search state, advanced on every accepted text beat.
  search_cfg_t         cur_cfg;
  logic [7:0]          window [WIN_DEPTH];
  logic [POS_BITS-1:0] text_pos;
  int                  fill;
  match_t              pending;
  match_t              first_after;
  match_t              first_any;
  match_t              last_before;
  match_t              last_any;
  result_t             expected_results [$];

  int        mismatches = 0;
  int        cycles = 0;
  int        burst_left = 0;
  int        tx_gap_max = 2;
  rx_style_e rx_style = RX_RANDOM;
  logic [7:0] rx_tick = '0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Character classes as the search sees them under the current delimiter maps.
  function automatic bit is_blank(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic bit is_sep(input logic [7:0] c);
    if (is_blank(c)) return 1'b1;
    if (c < 8'd64) return cur_cfg.dmap_lo[c[5:0]];
    if (c < 8'd128) return cur_cfg.dmap_hi[c[5:0]];
    return 1'b0;
  endfunction

  function automatic logic [7:0] fold_char(input logic [7:0] c);
    if (cur_cfg.mode[MODE_CASE] && (c >= 8'h41) && (c <= 8'h5A)) return c + 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] pattern_char(input int k);
    logic [127:0] bits;
    bits = {cur_cfg.pat_hi, cur_cfg.pat_lo};
    if (k >= PAT_REG_BYTES) return 8'h00;
    return bits[8*k +: 8];
  endfunction

  function automatic void clear_text();
    foreach (window[i]) window[i] = 8'h00;
    text_pos    = '0;
    fill        = 0;
    pending     = '0;
    first_after = '0;
    first_any   = '0;
    last_before = '0;
    last_any    = '0;
  endfunction

  // A confirmed match updates the four selection trackers.
  function automatic void record_match(input match_t m);
    int b;
    int s;
    b = int'(cur_cfg.begin_at);
    s = int'(m.start);
    if (!first_any.ok) first_any = m;
    if (!first_after.ok && (s >= ((b < 0) ? 0 : b))) first_after = m;
    if ((b >= 0) && (s <= b)) last_before = m;
    last_any = m;
  endfunction

  // Advances the search by one text byte; on the final byte the selected match
  // is queued as the expected result and the text state is cleared.
  function automatic void search_step(input logic [7:0] c, input bit last);
    int      len;
    bit      hit;
    bit      left_ok;
    match_t  pick;
    result_t res;
    for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = c;
    if (fill < PAT_MAX + 1) fill++;

    // A match waiting for its right neighbour is settled by this byte.
    if (pending.ok) begin
      if (!pending.need_right || is_sep(c)) record_match(pending);
      pending.ok = 1'b0;
    end

    len = (cur_cfg.plen > PAT_MAX) ? PAT_MAX : int'(cur_cfg.plen);
    if ((len > 0) && (fill >= len)) begin
      hit = 1'b1;
      for (int k = 0; k < len; k++) begin
        if (fold_char(window[len-1-k]) != fold_char(pattern_char(k))) hit = 1'b0;
      end
      if (hit) begin
        left_ok = 1'b1;
        if (cur_cfg.mode[MODE_WORD] && !is_sep(pattern_char(0))) begin
          left_ok = (fill == len) || is_sep(window[len]);
        end
        if (left_ok) begin
          pending.ok         = 1'b1;
          pending.start      = text_pos - POS_BITS'(len - 1);
          pending.stop       = {1'b0, pending.start} + (POS_BITS + 1)'(len);
          pending.need_right = cur_cfg.mode[MODE_WORD] && !is_sep(pattern_char(len - 1));
        end
      end
    end

    if (!last) begin
      text_pos++;
      return;
    end

    // The end of the text satisfies any right-hand word rule.
    if (pending.ok) record_match(pending);
    pick = '0;
    if (cur_cfg.mode[MODE_BACKWARD]) begin
      if ((cur_cfg.begin_at >= 0) && last_before.ok) pick = last_before;
      else if (cur_cfg.mode[MODE_WRAP] && last_any.ok) pick = last_any;
    end else begin
      if (first_after.ok) pick = first_after;
      else if (cur_cfg.mode[MODE_WRAP] && first_any.ok) pick = first_any;
    end
    res.found = pick.ok;
    res.start = pick.start;
    res.stop  = pick.stop;
    expected_results.push_back(res);
    clear_text();
  endfunction

  function automatic logic [3:0] mode_of(input bit nocase, input bit word, input bit back,
                                         input bit wrap);
    logic [3:0] m;
    m                = '0;
    m[MODE_CASE]     = nocase;
    m[MODE_WORD]     = word;
    m[MODE_BACKWARD] = back;
    m[MODE_WRAP]     = wrap;
    return m;
  endfunction

  // Mostly letters from a small alphabet so that short patterns recur, with
  // whitespace, punctuation and the odd arbitrary byte mixed in.
  function automatic logic [7:0] random_char();
    logic [7:0] pool [14] = '{8'h61, 8'h62, 8'h41, 8'h42, 8'h61, 8'h62, 8'h63,
                              8'h20, 8'h09, 8'h2C, 8'h2E, 8'h5D, 8'h7D, 8'h0D};
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    return pool[$urandom_range(0, 13)];
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Only called while the block is idle, so the shadow copy can change at once.
  task automatic load_settings(input search_cfg_t s);
    write_reg(CFG_PATTERN_LOW, s.pat_lo);
    write_reg(CFG_PATTERN_HIGH, s.pat_hi);
    write_reg(CFG_PATTERN_LEN, {59'd0, s.plen});
    write_reg(CFG_MODE, {60'd0, s.mode});
    write_reg(CFG_BEGIN_POS, {39'd0, s.begin_at});
    write_reg(CFG_DELIM_LOW, s.dmap_lo);
    write_reg(CFG_DELIM_HIGH, s.dmap_hi);
    cfg_we  <= 1'b0;
    cur_cfg = s;
  endtask

  // Drives one text beat and holds it until the block takes it.
  task automatic send_byte(input logic [7:0] c, input bit last);
    in_bus.valid     <= 1'b1;
    in_bus.text_byte <= c;
    in_bus.is_last   <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    search_step(c, last);
  endtask

  // Sends a whole text in bursts of random length separated by random gaps.
  task automatic send_text(input text_t text);
    int gap;
    foreach (text[i]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(0, 24);
        gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
          in_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
      send_byte(text[i], i == text.size() - 1);
    end
  endtask

  // Holds the sender back until every outstanding result has been taken.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // With the registers at their reset values the pattern is empty.
  task automatic test_reset_state();
    text_t t;
    t = '{8'h61, 8'h62};
    send_text(t);
    wait_idle();
  endtask

  // Overlapping matches, backward search from a negative begin with wrap, and
  // forward wrap from a begin past the end of the text with case folding.
  task automatic test_direction();
    search_cfg_t s;
    text_t       t;
    s = '{default: 0};
    s.pat_lo   = 64'h6161;
    s.plen     = 5'd2;
    s.mode     = mode_of(1'b0, 1'b0, 1'b1, 1'b1);
    s.begin_at = -25'sd1;
    load_settings(s);
    t = '{8'h61, 8'h61, 8'h61};
    send_text(t);
    wait_idle();
    s.mode     = mode_of(1'b1, 1'b0, 1'b0, 1'b1);
    s.begin_at = 25'sd9;
    load_settings(s);
    t = '{8'h61, 8'h41, 8'h61};
    send_text(t);
    wait_idle();
  endtask

  // Whole-word rule: a word character on the left rejects the first hit, a
  // bitmap delimiter on the left and the end of the text on the right accept
  // the second.
  task automatic test_word_rules();
    search_cfg_t s;
    text_t       t;
    s = '{default: 0};
    s.pat_lo  = 64'h6261;
    s.plen    = 5'd2;
    s.mode    = mode_of(1'b1, 1'b1, 1'b0, 1'b0);
    s.dmap_lo = 64'h0000_1000_0000_0000;
    s.dmap_hi = 64'h8000_0000_0000_0000;
    load_settings(s);
    t = '{8'h78, 8'h41, 8'h62, 8'h7F, 8'h61, 8'h62};
    send_text(t);
    wait_idle();
  endtask

  // Full-length pattern of extreme byte values, an over-long length setting,
  // the largest begin position and delimiter maps with every bit set.
  task automatic test_pattern_extremes();
    search_cfg_t s;
    text_t       t;
    s.pat_lo   = 64'h00FF_00FF_00FF_00FF;
    s.pat_hi   = 64'h00FF_00FF_00FF_00FF;
    s.plen     = 5'd31;
    s.mode     = mode_of(1'b0, 1'b1, 1'b1, 1'b1);
    s.begin_at = 25'sh0FF_FFFF;
    s.dmap_lo  = '1;
    s.dmap_hi  = '1;
    load_settings(s);
    for (int i = 0; i < PAT_MAX; i++) t.push_back((i % 2 == 0) ? 8'hFF : 8'h00);
    send_text(t);
    wait_idle();
  endtask

  // Phases of random settings and handshake styles; texts are built from
  // pattern copies, partial copies and random characters.
  task automatic test_random_traffic();
    search_cfg_t  s;
    text_t        t;
    logic [127:0] pbits;
    logic [7:0]   b;
    int           sent;
    int           texts;
    int           span;
    int           used;
    int           copy;
    int           pick;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      wait_idle();
      rx_style   = rx_style_e'($urandom_range(0, 2));
      tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);

      for (int k = 0; k < PAT_REG_BYTES; k++) pbits[8*k +: 8] = random_char();
      s.pat_lo = pbits[63:0];
      s.pat_hi = pbits[127:64];
      pick = $urandom_range(0, 19);
      if (pick == 0) s.plen = 5'd0;
      else if (pick == 1) s.plen = 5'(PAT_MAX);
      else if (pick == 2) s.plen = 5'($urandom_range(PAT_MAX + 1, 31));
      else if (pick < 6) s.plen = 5'($urandom_range(5, PAT_MAX - 1));
      else s.plen = 5'($urandom_range(1, 4));
      s.mode = 4'($urandom_range(0, 15));
      pick = $urandom_range(0, 9);
      if (pick == 0) s.begin_at = -25'sd1;
      else if (pick == 1) s.begin_at = 25'sh0FF_FFFF;
      else if (pick == 2) s.begin_at = 25'sh100_0000;
      else if (pick == 3) s.begin_at = 25'sd0;
      else s.begin_at = 25'($urandom_range(0, 40));
      pick = $urandom_range(0, 5);
      if (pick == 0) begin
        s.dmap_lo = '0;
        s.dmap_hi = '0;
      end else if (pick == 1) begin
        s.dmap_lo = '1;
        s.dmap_hi = '1;
      end else if (pick == 2) begin
        s.dmap_lo = {$urandom, $urandom};
        s.dmap_hi = {$urandom, $urandom};
      end else begin
        // Comma, full stop, colon, semicolon, brackets and braces.
        s.dmap_lo = 64'h0C00_5000_0000_0000;
        s.dmap_hi = 64'h2800_0000_2800_0000;
      end
      load_settings(s);

      used  = (s.plen > PAT_MAX) ? PAT_MAX : int'(s.plen);
      texts = $urandom_range(2, 6);
      repeat (texts) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) span = 1;
        else if (pick == 1) span = $urandom_range(120, 300);
        else span = $urandom_range(2, 30);
        t.delete();
        while (t.size() < span) begin
          if ((used > 0) && ($urandom_range(0, 2) == 0)) begin
            copy = ($urandom_range(0, 3) == 0) ? $urandom_range(1, used) : used;
            for (int k = 0; k < copy; k++) begin
              b = pbits[8*k +: 8];
              if ((((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A))) &&
                  ($urandom_range(0, 1) == 1)) begin
                b = b ^ 8'h20;
              end
              t.push_back(b);
            end
          end else begin
            t.push_back(random_char());
          end
        end
        while (t.size() > span) void'(t.pop_back());
        sent += t.size();
        send_text(t);
      end
    end
    wait_idle();
  endtask

  // Result receiver with its own stall pattern.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 8'd1;
    case (rx_style)
      RX_ALWAYS: begin
        out_bus.ready <= 1'b1;
      end
      RX_RANDOM: begin
        out_bus.ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        // Long stalls: ready only while the low five bits of the tick counter exceed 18.
        out_bus.ready <= (rx_tick[4:0] > 5'd18);
      end
    endcase
  end

  // Every result beat is compared with the oldest expectation.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected result beat found=%0d start=%0d end=%0d", $time,
                   out_bus.found, out_bus.match_start, out_bus.match_end);
        end
      end else begin
        want = expected_results.pop_front();
        if ((out_bus.found !== want.found) || (out_bus.match_start !== want.start) ||
            (out_bus.match_end !== want.stop)) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: expected found=%0d start=%0d end=%0d, got found=%0d start=%0d end=%0d",
                     $time, want.found, want.start, want.stop,
                     out_bus.found, out_bus.match_start, out_bus.match_end);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    in_bus.valid     <= 1'b0;
    in_bus.text_byte <= 8'h00;
    in_bus.is_last   <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    rst_n            <= 1'b0;
    cur_cfg = '{default: 0};
    clear_text();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_direction();
    test_word_rules();
    test_pattern_extremes();
    test_random_traffic();

    wait_idle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
